@@ rtl/aes_ke_pkg.sv @@
package aes_ke_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned LoadW  = 4;
  localparam int unsigned Depth  = 8;

  typedef enum logic [1:0] {
    KL_128 = 2'd0,
    KL_192 = 2'd1,
    KL_256 = 2'd2,
    KL_RSV = 2'd3
  } key_len_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BYTE
  } ke_state_t;

  // controls from the sequencer to the byte datapath
  typedef struct packed {
    logic load;
    logic step;
    logic rot;
    logic use_sub;
    logic add_rcon;
  } ke_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    logic [7:0] d;
    d = {b[6:0], 1'b0};
    return b[7] ? (d ^ 8'h1b) : d;
  endfunction

  // reserved code runs as a 256-bit key
  function automatic key_len_t eff_len(input logic [1:0] code);
    key_len_t k;
    case (code)
      KL_128:  k = KL_128;
      KL_192:  k = KL_192;
      default: k = KL_256;
    endcase
    return k;
  endfunction

  function automatic logic [LoadW-1:0] nk_of(input key_len_t k);
    logic [LoadW-1:0] n;
    case (k)
      KL_128:  n = 4'd4;
      KL_192:  n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // index of the final schedule word, 4*(Nk+7)-1
  function automatic logic [IdxW-1:0] last_idx_of(input key_len_t k);
    logic [IdxW-1:0] n;
    case (k)
      KL_128:  n = 6'd43;
      KL_192:  n = 6'd51;
      default: n = 6'd59;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/aes_ke_window.sv @@
module aes_ke_window (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic [aes_ke_pkg::WordW-1:0]   shift_in,
  input  aes_ke_pkg::key_len_t           key_len,
  output logic [aes_ke_pkg::WordW-1:0]   prev_word,
  output logic [aes_ke_pkg::WordW-1:0]   back_word
);

  // taps[0] holds word i-1, taps[Nk-1] holds word i-Nk
  logic [aes_ke_pkg::WordW-1:0] taps [aes_ke_pkg::Depth];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      taps[0] <= shift_in;
      for (int k = 1; k < aes_ke_pkg::Depth; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign prev_word = taps[0];

  always_comb begin
    case (key_len)
      aes_ke_pkg::KL_128: back_word = taps[3];
      aes_ke_pkg::KL_192: back_word = taps[5];
      default:            back_word = taps[7];
    endcase
  end

endmodule

@@ rtl/aes_ke_byte_unit.sv @@
module aes_ke_byte_unit (
  input  logic                           clk,
  input  aes_ke_pkg::ke_ctrl_t           ctrl,
  input  logic [aes_ke_pkg::WordW-1:0]   prev_word,
  input  logic [aes_ke_pkg::WordW-1:0]   back_word,
  input  logic [aes_ke_pkg::ByteW-1:0]   rcon,
  output logic [aes_ke_pkg::WordW-1:0]   new_word
);

  logic [aes_ke_pkg::WordW-1:0] src;
  logic [aes_ke_pkg::WordW-1:0] old;
  logic [aes_ke_pkg::WordW-1:0] acc;
  logic [aes_ke_pkg::ByteW-1:0] sub_byte;
  logic [aes_ke_pkg::ByteW-1:0] t_byte;
  logic [aes_ke_pkg::ByteW-1:0] new_byte;

  // one byte per cycle while stepping, most significant first
  assign sub_byte = aes_ke_pkg::SBOX[src[31:24]];

  always_comb begin
    t_byte = ctrl.use_sub ? sub_byte : src[31:24];
    if (ctrl.add_rcon) begin
      t_byte = t_byte ^ rcon;
    end
    new_byte = t_byte ^ old[31:24];
  end

  assign new_word = {acc[23:0], new_byte};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      src <= ctrl.rot ? {prev_word[23:0], prev_word[31:24]} : prev_word;
      old <= back_word;
    end else if (ctrl.step) begin
      src <= {src[23:0], 8'h00};
      old <= {old[23:0], 8'h00};
      acc <= new_word;
    end
  end

endmodule

@@ rtl/aes_key_expansion.sv @@
// Key words: one per cycle while busy is low; each is echoed on the result
// ports the cycle after its transfer. After the last key word the schedule
// is built one byte per cycle, each word a load step and then 4 bytes, and
// busy stays high until the final schedule word is built, so no key word is
// taken meanwhile. Results cannot be stalled. Synchronous reset clears the
// length code to 128 bits and restarts key loading.
module aes_key_expansion (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [aes_ke_pkg::WordW-1:0]  key_word,
  input  logic                          key_length_we,
  input  logic [1:0]                    key_length_code,
  output logic                          word_valid,
  output logic [aes_ke_pkg::WordW-1:0]  round_word,
  output logic [aes_ke_pkg::IdxW-1:0]   word_index,
  output logic                          last_word
);

  aes_ke_pkg::ke_state_t         state;
  aes_ke_pkg::ke_state_t         state_next;
  aes_ke_pkg::ke_ctrl_t          ctrl;
  aes_ke_pkg::key_len_t          key_len;

  logic [1:0]                    len_code;
  logic [aes_ke_pkg::LoadW-1:0]  loaded;
  logic [aes_ke_pkg::IdxW-1:0]   idx;
  logic [aes_ke_pkg::ByteW-1:0]  rcon;
  logic [2:0]                    rem;
  logic [1:0]                    byte_cnt;

  logic                          accept;
  logic                          word_done;
  logic                          sched_end;
  logic [aes_ke_pkg::LoadW-1:0]  nk;
  logic [aes_ke_pkg::LoadW-1:0]  loaded_inc;
  logic [2:0]                    rem_max;
  logic [aes_ke_pkg::IdxW-1:0]   last_idx;

  logic [aes_ke_pkg::WordW-1:0]  prev_word;
  logic [aes_ke_pkg::WordW-1:0]  back_word;
  logic [aes_ke_pkg::WordW-1:0]  new_word;
  logic                          shift_en;
  logic [aes_ke_pkg::WordW-1:0]  shift_in;

  assign key_len    = aes_ke_pkg::eff_len(len_code);
  assign nk         = aes_ke_pkg::nk_of(key_len);
  assign last_idx   = aes_ke_pkg::last_idx_of(key_len);
  assign rem_max    = 3'(nk - 4'd1);
  assign loaded_inc = loaded + 4'd1;

  assign busy      = (state != aes_ke_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign word_done = ctrl.step && (byte_cnt == 2'd3);
  assign sched_end = word_done && (idx == last_idx);

  assign shift_en = accept || word_done;
  assign shift_in = accept ? key_word : new_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes_ke_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.load     = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.rot      = (rem == 3'd0);
    ctrl.use_sub  = (rem == 3'd0) || (key_len == aes_ke_pkg::KL_256 && rem == 3'd4);
    ctrl.add_rcon = (rem == 3'd0) && (byte_cnt == 2'd0);
    case (state)
      aes_ke_pkg::ST_IDLE: begin
        if (start && loaded_inc == nk) begin
          state_next = aes_ke_pkg::ST_LOAD;
        end
      end
      aes_ke_pkg::ST_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = aes_ke_pkg::ST_BYTE;
      end
      aes_ke_pkg::ST_BYTE: begin
        ctrl.step = 1'b1;
        if (byte_cnt == 2'd3) begin
          state_next = (idx == last_idx) ? aes_ke_pkg::ST_IDLE : aes_ke_pkg::ST_LOAD;
        end
      end
      default: state_next = aes_ke_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_code   <= aes_ke_pkg::KL_128;
      loaded     <= '0;
      idx        <= '0;
      rcon       <= 8'h01;
      rem        <= '0;
      byte_cnt   <= '0;
      word_valid <= 1'b0;
    end else begin
      word_valid <= accept || word_done;
      if (key_length_we) begin
        len_code <= key_length_code;
      end
      if (key_length_we || sched_end) begin
        loaded <= '0;
        idx    <= '0;
        rcon   <= 8'h01;
        rem    <= '0;
      end else if (accept) begin
        loaded <= loaded_inc;
        idx    <= idx + 6'd1;
      end else if (word_done) begin
        idx <= idx + 6'd1;
        rem <= (rem == rem_max) ? 3'd0 : rem + 3'd1;
        if (rem == 3'd0) begin
          rcon <= aes_ke_pkg::xtime(rcon);
        end
      end
      if (ctrl.load) begin
        byte_cnt <= '0;
      end else if (ctrl.step) begin
        byte_cnt <= byte_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      round_word <= key_word;
      word_index <= idx;
      last_word  <= 1'b0;
    end else if (word_done) begin
      round_word <= new_word;
      word_index <= idx;
      last_word  <= (idx == last_idx);
    end
  end

  aes_ke_window u_window (
    .clk       (clk),
    .shift_en  (shift_en),
    .shift_in  (shift_in),
    .key_len   (key_len),
    .prev_word (prev_word),
    .back_word (back_word)
  );

  aes_ke_byte_unit u_byte_unit (
    .clk       (clk),
    .ctrl      (ctrl),
    .prev_word (prev_word),
    .back_word (back_word),
    .rcon      (rcon),
    .new_word  (new_word)
  );

endmodule

@@ test/aes_schedule_checker.sv @@
module aes_schedule_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [aes_ke_pkg::WordW-1:0]  key_word,
  input  logic                          key_length_we,
  input  logic [1:0]                    key_length_code,
  input  logic                          word_valid,
  input  logic [aes_ke_pkg::WordW-1:0]  round_word,
  input  logic [aes_ke_pkg::IdxW-1:0]   word_index,
  input  logic                          last_word,
  output int                            mismatch_count,
  output int                            outstanding_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [aes_ke_pkg::WordW-1:0] word;
    logic [aes_ke_pkg::IdxW-1:0]  idx;
    logic                         last;
  } sched_word_t;

  sched_word_t                  expected_words[$];
  logic [1:0]                   len_code;
  logic [aes_ke_pkg::WordW-1:0] window [aes_ke_pkg::Depth];
  logic [aes_ke_pkg::LoadW-1:0] loaded;
  logic [aes_ke_pkg::IdxW-1:0]  next_idx;
  logic [aes_ke_pkg::ByteW-1:0] rcon;

  function automatic logic [aes_ke_pkg::WordW-1:0] sbox_word(
    input logic [aes_ke_pkg::WordW-1:0] w);
    return {aes_ke_pkg::SBOX[w[31:24]], aes_ke_pkg::SBOX[w[23:16]],
            aes_ke_pkg::SBOX[w[15:8]], aes_ke_pkg::SBOX[w[7:0]]};
  endfunction

  task automatic restart_key();
    loaded = '0;
    next_idx = '0;
    rcon = 8'h01;
  endtask

  task automatic queue_word(input logic [aes_ke_pkg::WordW-1:0] w, input int idx,
                            input logic last);
    sched_word_t e;
    e.word = w;
    e.idx = idx[aes_ke_pkg::IdxW-1:0];
    e.last = last;
    expected_words.push_back(e);
  endtask

  // one accepted key word: echo it, and on the last key word build the rest
  task automatic expand_key_word(input logic [aes_ke_pkg::WordW-1:0] kw);
    int nk;
    int total;
    logic [aes_ke_pkg::WordW-1:0] t;
    nk = (len_code == aes_ke_pkg::KL_128) ? 4 : (len_code == aes_ke_pkg::KL_192) ? 6 : 8;
    total = 4 * (nk + 7);
    window[next_idx[2:0]] = kw;
    queue_word(kw, int'(next_idx), 1'b0);
    loaded = loaded + 4'd1;
    next_idx = next_idx + 6'd1;
    if (int'(loaded) >= nk) begin
      for (int i = nk; i < total; i++) begin
        t = window[3'(i - 1)];
        if (i % nk == 0) begin
          t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
        end else if (nk == 8 && i % nk == 4) begin
          t = sbox_word(t);
        end
        t = t ^ window[3'(i - nk)];
        window[3'(i)] = t;
        queue_word(t, i, i == total - 1);
      end
      restart_key();
    end
  endtask

  always @(posedge clk) begin
    sched_word_t e;
    if (rst) begin
      len_code = aes_ke_pkg::KL_128;
      restart_key();
      expected_words.delete();
    end else begin
      if (word_valid) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected word %h idx %0d last %b", $realtime, round_word,
                     word_index, last_word);
        end else begin
          e = expected_words.pop_front();
          if (round_word !== e.word || word_index !== e.idx || last_word !== e.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: word mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                       $realtime, e.word, e.idx, e.last, round_word, word_index, last_word);
          end
        end
      end
      if (key_length_we) begin
        len_code = key_length_code;
        restart_key();
      end
      if (start && !busy)
        expand_key_word(key_word);
    end
    outstanding_words = expected_words.size();
  end

endmodule

@@ test/tb_aes_key_expansion.sv @@
module tb_aes_key_expansion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 250;
  localparam int StallLimit  = 1000;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [aes_ke_pkg::WordW-1:0] key_word;
  logic                         key_length_we;
  logic [1:0]                   key_length_code;
  logic                         word_valid;
  logic [aes_ke_pkg::WordW-1:0] round_word;
  logic [aes_ke_pkg::IdxW-1:0]  word_index;
  logic                         last_word;
  int                           mismatch_count;
  int                           outstanding_words;
  int                           stall_cycles;
  int                           words_sent;
  bit                           no_gaps;

  aes_key_expansion u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .key_word        (key_word),
    .key_length_we   (key_length_we),
    .key_length_code (key_length_code),
    .word_valid      (word_valid),
    .round_word      (round_word),
    .word_index      (word_index),
    .last_word       (last_word)
  );

  aes_schedule_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .key_word          (key_word),
    .key_length_we     (key_length_we),
    .key_length_code   (key_length_code),
    .word_valid        (word_valid),
    .round_word        (round_word),
    .word_index        (word_index),
    .last_word         (last_word),
    .mismatch_count    (mismatch_count),
    .outstanding_words (outstanding_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || word_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_aes_key_expansion: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int key_words_for(input logic [1:0] code);
    return (code == aes_ke_pkg::KL_128) ? 4 : (code == aes_ke_pkg::KL_192) ? 6 : 8;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [aes_ke_pkg::WordW-1:0] pick_key_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // called at a falling edge; leaves start high after the transfer
  task automatic send_key_word(input logic [aes_ke_pkg::WordW-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    key_word = w;
    do @(posedge clk); while (busy);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (busy || outstanding_words != 0) @(negedge clk);
    // wait on past the final word before touching the register
    repeat (6) @(negedge clk);
  endtask

  task automatic write_length(input logic [1:0] code);
    wait_idle();
    key_length_we = 1'b1;
    key_length_code = code;
    @(negedge clk);
    key_length_we = 1'b0;
    no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [1:0] code;
    int nk;
    int n_keys;
    int target;
    rst = 1'b1;
    start = 1'b0;
    key_word = '0;
    key_length_we = 1'b0;
    key_length_code = aes_ke_pkg::KL_128;
    words_sent = 0;
    no_gaps = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 128-bit all-ones key at the reset length
    repeat (4) send_key_word('1);
    // partial 192-bit key cut off by a length write
    write_length(aes_ke_pkg::KL_192);
    repeat (3) send_key_word(pick_key_word());
    write_length(aes_ke_pkg::KL_256);
    repeat (8) send_key_word('0);
    // reserved code runs as 256 bits
    write_length(aes_ke_pkg::KL_RSV);
    for (int j = 0; j < 8; j++)
      send_key_word(32'h00010203 + 32'h04040404 * j);

    target = words_sent + RandomWords;
    while (words_sent < target) begin
      code = 2'($urandom_range(0, 3));
      nk = key_words_for(code);
      write_length(code);
      n_keys = $urandom_range(1, 3);
      repeat (n_keys) begin
        repeat (nk) send_key_word(pick_key_word());
      end
      // now and then leave a key partly loaded; the next write restarts it
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, nk - 1)) send_key_word(pick_key_word());
    end

    start = 1'b0;
    while (outstanding_words != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding_words == 0) begin
      $display("tb_aes_key_expansion: PASS");
    end else begin
      $display("tb_aes_key_expansion: FAIL");
    end
    $finish;
  end

endmodule
